[hdl/cap_pkg.sv]
package cap_pkg;

   // Field and register widths
   localparam int COORD_BITS     = 32;
   localparam int FRAC_BITS      = 16;
   localparam int TS_BITS        = 16;
   localparam int CSR_BITS       = 31;
   localparam int CSR_INDEX_BITS = 2;

   // Distance path: magnitudes are cut down to this width before squaring
   localparam int QMAG_BITS  = 31;
   localparam int SHIFT_MAX  = (COORD_BITS > QMAG_BITS) ? COORD_BITS - QMAG_BITS : 0;
   localparam int SHIFT_BITS = $clog2(SHIFT_MAX + 2);
   localparam int ROOT_BITS  = QMAG_BITS + 1;
   localparam int RAD_BITS   = ROOT_BITS + SHIFT_MAX;
   localparam int QUO_BITS   = CSR_BITS;

   // Register reset values
   localparam logic [TS_BITS-1:0]  TIME_STEP_RESET     = TS_BITS'(1092);
   localparam logic [CSR_BITS-1:0] PULL_STRENGTH_RESET = CSR_BITS'(65536000);
   localparam logic [CSR_BITS-1:0] ACCEL_FLOOR_RESET   = CSR_BITS'(6554);
   localparam logic [CSR_BITS-1:0] ACCEL_CEILING_RESET = CSR_BITS'(65536000);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_TIME_STEP,
      CSR_PULL_STRENGTH,
      CSR_ACCEL_FLOOR,
      CSR_ACCEL_CEILING
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] pos_x;
      logic signed [COORD_BITS-1:0] pos_y;
      logic signed [COORD_BITS-1:0] vel_x;
      logic signed [COORD_BITS-1:0] vel_y;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] new_pos_x;
      logic signed [COORD_BITS-1:0] new_pos_y;
      logic signed [COORD_BITS-1:0] new_vel_x;
      logic signed [COORD_BITS-1:0] new_vel_y;
      logic                         saturated;
   } rsp_type;

   // Per-item data that rides alongside the sqrt and divide pipelines
   typedef struct packed {
      logic signed [COORD_BITS-1:0] pos_x;
      logic signed [COORD_BITS-1:0] pos_y;
      logic signed [COORD_BITS-1:0] vel_x;
      logic signed [COORD_BITS-1:0] vel_y;
      logic [COORD_BITS-1:0]        mag_x;
      logic [COORD_BITS-1:0]        mag_y;
      logic                         neg_x;
      logic                         neg_y;
      logic [SHIFT_BITS-1:0]        shift;
   } side_type;

endpackage

[hdl/cap_delay.sv]
module cap_delay #(
   parameter int WIDTH = cap_pkg::COORD_BITS,
   parameter int DEPTH = cap_pkg::ROOT_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   output logic [WIDTH-1:0] out_data
);

   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] data_ff [DEPTH];

   // Valid bits, cleared on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < DEPTH; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   // Payload taps
   always_ff @(posedge clock) begin
      data_ff[0] <= in_data;
      for (int i = 1; i < DEPTH; i++) begin
         data_ff[i] <= data_ff[i-1];
      end
   end

   assign out_valid = valid_ff[DEPTH-1];
   assign out_data  = data_ff[DEPTH-1];

endmodule

[hdl/cap_sqrt.sv]
module cap_sqrt #(
   parameter int ROOT_BITS = cap_pkg::ROOT_BITS
) (
   input  logic                     clock,
   input  logic [2*ROOT_BITS-1:0]   radicand,
   output logic [ROOT_BITS-1:0]     root
);

   localparam int RAD_W = 2 * ROOT_BITS;

   logic [RAD_W-1:0]     rem_ff  [ROOT_BITS];
   logic [ROOT_BITS-1:0] root_ff [ROOT_BITS];
   logic [RAD_W-1:0]     rem_in  [ROOT_BITS];
   logic [ROOT_BITS-1:0] root_in [ROOT_BITS];

   // One root bit per stage, most significant first: floor square root
   always_comb begin
      logic [RAD_W-1:0]     rem_prev;
      logic [ROOT_BITS-1:0] root_prev;
      logic [RAD_W-1:0]     trial;
      for (int j = 0; j < ROOT_BITS; j++) begin
         rem_prev  = (j == 0) ? radicand : rem_ff[(j == 0) ? 0 : j - 1];
         root_prev = (j == 0) ? '0 : root_ff[(j == 0) ? 0 : j - 1];
         // (2*root + bit) * bit with bit = 2^(ROOT_BITS-1-j)
         trial = (RAD_W'(root_prev) << (ROOT_BITS - j))
               | (RAD_W'(1) << (2 * (ROOT_BITS - 1 - j)));
         if (rem_prev >= trial) begin
            rem_in[j]  = rem_prev - trial;
            root_in[j] = root_prev | (ROOT_BITS'(1) << (ROOT_BITS - 1 - j));
         end else begin
            rem_in[j]  = rem_prev;
            root_in[j] = root_prev;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < ROOT_BITS; j++) begin
         rem_ff[j]  <= rem_in[j];
         root_ff[j] <= root_in[j];
      end
   end

   assign root = root_ff[ROOT_BITS-1];

endmodule

[hdl/cap_div.sv]
module cap_div #(
   parameter int NUM_W    = cap_pkg::CSR_BITS + cap_pkg::FRAC_BITS,
   parameter int DEN_W    = cap_pkg::RAD_BITS,
   parameter int QUO_BITS = cap_pkg::QUO_BITS
) (
   input  logic                clock,
   input  logic [NUM_W-1:0]    numer,
   input  logic [DEN_W-1:0]    denom,
   output logic [QUO_BITS-1:0] quotient,
   output logic                overflow
);

   localparam int W = (NUM_W > DEN_W + QUO_BITS) ? NUM_W : DEN_W + QUO_BITS;

   logic [W-1:0]        rem_ff [QUO_BITS+1];
   logic [DEN_W-1:0]    den_ff [QUO_BITS+1];
   logic [QUO_BITS-1:0] quo_ff [QUO_BITS+1];
   logic                ovf_ff [QUO_BITS+1];
   logic [W-1:0]        rem_in [QUO_BITS];
   logic [QUO_BITS-1:0] quo_in [QUO_BITS];

   // Entry stage: quotient too wide for QUO_BITS (or zero divisor) flags overflow
   always_ff @(posedge clock) begin
      rem_ff[0] <= W'(numer);
      den_ff[0] <= denom;
      quo_ff[0] <= '0;
      ovf_ff[0] <= W'(numer) >= (W'(denom) << QUO_BITS);
   end

   // Restoring long division, one quotient bit per stage
   always_comb begin
      logic [W-1:0] trial;
      for (int j = 0; j < QUO_BITS; j++) begin
         trial = W'(den_ff[j]) << (QUO_BITS - 1 - j);
         if (rem_ff[j] >= trial) begin
            rem_in[j] = rem_ff[j] - trial;
            quo_in[j] = quo_ff[j] | (QUO_BITS'(1) << (QUO_BITS - 1 - j));
         end else begin
            rem_in[j] = rem_ff[j];
            quo_in[j] = quo_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < QUO_BITS; j++) begin
         rem_ff[j+1] <= rem_in[j];
         den_ff[j+1] <= den_ff[j];
         quo_ff[j+1] <= quo_in[j];
         ovf_ff[j+1] <= ovf_ff[j];
      end
   end

   assign quotient = quo_ff[QUO_BITS];
   assign overflow = ovf_ff[QUO_BITS];

endmodule

[hdl/central_attractor_particle_step.sv]
// Pipeline: after the input register, each item passes through 3 front, 32 square root,
// 1 radius, 32 divide and 6 tail stages before rsp_strobe marks its result.
// Throughput: one item per cycle; the sqrt and divide units take one bit per stage.
// Reset: synchronous, active high; clears all valid bits and restores the registers.
// busy is high only during reset. Results cannot be stalled by the receiver.
module central_attractor_particle_step (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  cap_pkg::req_type                    req_item,
   output logic                                rsp_strobe,
   output cap_pkg::rsp_type                    rsp_item,
   input  logic                                csr_we,
   input  logic [cap_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [cap_pkg::CSR_BITS-1:0]        csr_wdata
);

   localparam int CB     = cap_pkg::COORD_BITS;
   localparam int FB     = cap_pkg::FRAC_BITS;
   localparam int TSB    = cap_pkg::TS_BITS;
   localparam int CSB    = cap_pkg::CSR_BITS;
   localparam int QMB    = cap_pkg::QMAG_BITS;
   localparam int RTB    = cap_pkg::ROOT_BITS;
   localparam int RDB    = cap_pkg::RAD_BITS;
   localparam int QUB    = cap_pkg::QUO_BITS;
   localparam int SHB    = cap_pkg::SHIFT_BITS;
   localparam int ACC_W  = CSB + 1;
   localparam int SUM_W  = ((CB > ACC_W + 1) ? CB : ACC_W + 1) + 1;
   localparam int SIDE_W = $bits(cap_pkg::side_type);
   localparam logic [FB:0] UNIT = (FB + 1)'(1) << FB;

   // Clip to the coordinate range; top bit is the clip flag
   function automatic logic [CB:0] clip_coord(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = {{(SUM_W - CB + 1){1'b0}}, {(CB - 1){1'b1}}};
      lo = ~hi;
      if (v > hi) begin
         return {1'b1, hi[CB-1:0]};
      end else if (v < lo) begin
         return {1'b1, lo[CB-1:0]};
      end else begin
         return {1'b0, v[CB-1:0]};
      end
   endfunction

   // Configuration registers
   logic [TSB-1:0] ts_ff;
   logic [CSB-1:0] pull_ff, floor_ff, ceil_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ts_ff    <= cap_pkg::TIME_STEP_RESET;
         pull_ff  <= cap_pkg::PULL_STRENGTH_RESET;
         floor_ff <= cap_pkg::ACCEL_FLOOR_RESET;
         ceil_ff  <= cap_pkg::ACCEL_CEILING_RESET;
      end else if (csr_we) begin
         case (cap_pkg::csr_index_type'(csr_index))
            cap_pkg::CSR_TIME_STEP:     ts_ff    <= csr_wdata[TSB-1:0];
            cap_pkg::CSR_PULL_STRENGTH: pull_ff  <= csr_wdata;
            cap_pkg::CSR_ACCEL_FLOOR:   floor_ff <= csr_wdata;
            cap_pkg::CSR_ACCEL_CEILING: ceil_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy = reset;

   // Stage 0: input register
   logic             in_valid_ff;
   cap_pkg::req_type in_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start;
      end
      in_item_ff <= req_item;
   end

   // Stage 1: magnitudes, range shift, reduced magnitudes
   logic [CB-1:0]     ax_in, ay_in, big_in;
   logic [SHB-1:0]    sh_in;
   cap_pkg::side_type side1_in;

   always_comb begin
      ax_in = in_item_ff.pos_x[CB-1] ? (~in_item_ff.pos_x) + CB'(1) : in_item_ff.pos_x;
      ay_in = in_item_ff.pos_y[CB-1] ? (~in_item_ff.pos_y) + CB'(1) : in_item_ff.pos_y;
      big_in = (ax_in > ay_in) ? ax_in : ay_in;
      sh_in = '0;
      for (int k = 1; k <= cap_pkg::SHIFT_MAX; k++) begin
         if ((big_in >> (QMB - 1 + k)) != '0) begin
            sh_in = SHB'(k);
         end
      end
      side1_in.pos_x = in_item_ff.pos_x;
      side1_in.pos_y = in_item_ff.pos_y;
      side1_in.vel_x = in_item_ff.vel_x;
      side1_in.vel_y = in_item_ff.vel_y;
      side1_in.mag_x = ax_in;
      side1_in.mag_y = ay_in;
      side1_in.neg_x = in_item_ff.pos_x[CB-1];
      side1_in.neg_y = in_item_ff.pos_y[CB-1];
      side1_in.shift = sh_in;
   end

   logic              s1_valid_ff;
   cap_pkg::side_type s1_side_ff;
   logic [QMB-1:0]    s1_qx_ff, s1_qy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid_ff;
      end
      s1_side_ff <= side1_in;
      s1_qx_ff   <= QMB'(ax_in >> sh_in);
      s1_qy_ff   <= QMB'(ay_in >> sh_in);
   end

   // Stage 2: squares
   logic              s2_valid_ff;
   cap_pkg::side_type s2_side_ff;
   logic [2*QMB-1:0]  s2_sqx_ff, s2_sqy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_side_ff <= s1_side_ff;
      s2_sqx_ff  <= s1_qx_ff * s1_qx_ff;
      s2_sqy_ff  <= s1_qy_ff * s1_qy_ff;
   end

   // Stage 3: sum of squares
   logic              s3_valid_ff;
   cap_pkg::side_type s3_side_ff;
   logic [2*RTB-1:0]  s3_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_side_ff <= s2_side_ff;
      s3_sum_ff  <= (2 * RTB)'(s2_sqx_ff) + (2 * RTB)'(s2_sqy_ff);
   end

   // Square root, side data delayed to match
   logic [RTB-1:0]    root;
   logic              sq_valid;
   logic [SIDE_W-1:0] sq_side_bits;
   cap_pkg::side_type sq_side;

   cap_sqrt #(.ROOT_BITS(RTB)) u_sqrt (
      .clock    (clock),
      .radicand (s3_sum_ff),
      .root     (root)
   );

   cap_delay #(.WIDTH(SIDE_W), .DEPTH(RTB)) u_sqrt_side (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid_ff),
      .in_data   (s3_side_ff),
      .out_valid (sq_valid),
      .out_data  (sq_side_bits)
   );

   assign sq_side = cap_pkg::side_type'(sq_side_bits);

   // Radius stage: undo the range shift
   logic              r_valid_ff;
   cap_pkg::side_type r_side_ff;
   logic [RDB-1:0]    r_ff;
   logic              r_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
      end else begin
         r_valid_ff <= sq_valid;
      end
      r_side_ff <= sq_side;
      r_ff      <= RDB'(root) << sq_side.shift;
      r_zero_ff <= (root == '0);
   end

   // Pull magnitude and unit vector divides, run side by side
   logic [QUB-1:0]    quo_m, quo_x, quo_y;
   logic              ovf_m, ovf_x, ovf_y;
   logic              dv_valid;
   logic [SIDE_W:0]   dv_bits;
   cap_pkg::side_type dv_side;
   logic              dv_zero;

   cap_div #(.NUM_W(CSB + FB), .DEN_W(RDB), .QUO_BITS(QUB)) u_div_pull (
      .clock    (clock),
      .numer    ({pull_ff, {FB{1'b0}}}),
      .denom    (r_ff),
      .quotient (quo_m),
      .overflow (ovf_m)
   );

   cap_div #(.NUM_W(CB + FB), .DEN_W(RDB), .QUO_BITS(QUB)) u_div_x (
      .clock    (clock),
      .numer    ({r_side_ff.mag_x, {FB{1'b0}}}),
      .denom    (r_ff),
      .quotient (quo_x),
      .overflow (ovf_x)
   );

   cap_div #(.NUM_W(CB + FB), .DEN_W(RDB), .QUO_BITS(QUB)) u_div_y (
      .clock    (clock),
      .numer    ({r_side_ff.mag_y, {FB{1'b0}}}),
      .denom    (r_ff),
      .quotient (quo_y),
      .overflow (ovf_y)
   );

   cap_delay #(.WIDTH(SIDE_W + 1), .DEPTH(QUB + 1)) u_div_side (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (r_valid_ff),
      .in_data   ({r_zero_ff, r_side_ff}),
      .out_valid (dv_valid),
      .out_data  (dv_bits)
   );

   assign dv_zero = dv_bits[SIDE_W];
   assign dv_side = cap_pkg::side_type'(dv_bits[SIDE_W-1:0]);

   // Clamp stage: pull to [floor, ceiling], ceiling wins; unit parts to one
   logic [CSB-1:0] m_in;
   logic [FB:0]    ux_in, uy_in;

   always_comb begin
      if (ovf_m) begin
         m_in = ceil_ff;
      end else begin
         m_in = quo_m;
         if (m_in < floor_ff) begin
            m_in = floor_ff;
         end
         if (m_in > ceil_ff) begin
            m_in = ceil_ff;
         end
      end
      ux_in = (ovf_x || quo_x > QUB'(UNIT)) ? UNIT : quo_x[FB:0];
      uy_in = (ovf_y || quo_y > QUB'(UNIT)) ? UNIT : quo_y[FB:0];
   end

   logic              m_valid_ff, m_zero_ff;
   cap_pkg::side_type m_side_ff;
   logic [CSB-1:0]    m_ff;
   logic [FB:0]       ux_ff, uy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= dv_valid;
      end
      m_side_ff <= dv_side;
      m_zero_ff <= dv_zero;
      m_ff      <= m_in;
      ux_ff     <= ux_in;
      uy_ff     <= uy_in;
   end

   // Acceleration components; none at the origin
   logic [CSB+FB:0] prod_ax, prod_ay;

   assign prod_ax = m_ff * ux_ff;
   assign prod_ay = m_ff * uy_ff;

   logic              a_valid_ff;
   cap_pkg::side_type a_side_ff;
   logic [ACC_W-1:0]  acc_x_ff, acc_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= m_valid_ff;
      end
      a_side_ff <= m_side_ff;
      acc_x_ff  <= m_zero_ff ? '0 : ACC_W'(prod_ax >> FB);
      acc_y_ff  <= m_zero_ff ? '0 : ACC_W'(prod_ay >> FB);
   end

   // Velocity change = acc * dt
   logic [ACC_W+TSB-1:0] prod_dx, prod_dy;

   assign prod_dx = acc_x_ff * ts_ff;
   assign prod_dy = acc_y_ff * ts_ff;

   logic              d_valid_ff;
   cap_pkg::side_type d_side_ff;
   logic [ACC_W-1:0]  dv_x_ff, dv_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= a_valid_ff;
      end
      d_side_ff <= a_side_ff;
      dv_x_ff   <= ACC_W'(prod_dx >> FB);
      dv_y_ff   <= ACC_W'(prod_dy >> FB);
   end

   // New velocity, pulled against the position sign, clipped
   logic signed [SUM_W-1:0] vx_ext, vy_ext, dvx_ext, dvy_ext;
   logic [CB:0]             nvx_clip, nvy_clip;

   always_comb begin
      vx_ext  = {{(SUM_W - CB){d_side_ff.vel_x[CB-1]}}, d_side_ff.vel_x};
      vy_ext  = {{(SUM_W - CB){d_side_ff.vel_y[CB-1]}}, d_side_ff.vel_y};
      dvx_ext = {{(SUM_W - ACC_W){1'b0}}, dv_x_ff};
      dvy_ext = {{(SUM_W - ACC_W){1'b0}}, dv_y_ff};
      nvx_clip = clip_coord(d_side_ff.neg_x ? vx_ext + dvx_ext : vx_ext - dvx_ext);
      nvy_clip = clip_coord(d_side_ff.neg_y ? vy_ext + dvy_ext : vy_ext - dvy_ext);
   end

   logic                  v_valid_ff, v_clip_ff;
   logic signed [CB-1:0]  v_px_ff, v_py_ff, v_nvx_ff, v_nvy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_valid_ff <= 1'b0;
      end else begin
         v_valid_ff <= d_valid_ff;
      end
      v_px_ff   <= d_side_ff.pos_x;
      v_py_ff   <= d_side_ff.pos_y;
      v_nvx_ff  <= nvx_clip[CB-1:0];
      v_nvy_ff  <= nvy_clip[CB-1:0];
      v_clip_ff <= nvx_clip[CB] | nvy_clip[CB];
   end

   // Position change magnitude = |v'| * dt
   logic [CB-1:0]     nvx_mag, nvy_mag;
   logic [CB+TSB-1:0] prod_px, prod_py;

   always_comb begin
      nvx_mag = v_nvx_ff[CB-1] ? (~v_nvx_ff) + CB'(1) : v_nvx_ff;
      nvy_mag = v_nvy_ff[CB-1] ? (~v_nvy_ff) + CB'(1) : v_nvy_ff;
      prod_px = nvx_mag * ts_ff;
      prod_py = nvy_mag * ts_ff;
   end

   logic                 p_valid_ff, p_clip_ff;
   logic signed [CB-1:0] p_px_ff, p_py_ff, p_nvx_ff, p_nvy_ff;
   logic [CB-1:0]        p_dx_ff, p_dy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= v_valid_ff;
      end
      p_px_ff   <= v_px_ff;
      p_py_ff   <= v_py_ff;
      p_nvx_ff  <= v_nvx_ff;
      p_nvy_ff  <= v_nvy_ff;
      p_clip_ff <= v_clip_ff;
      p_dx_ff   <= CB'(prod_px >> FB);
      p_dy_ff   <= CB'(prod_py >> FB);
   end

   // New position with the sign of v', clipped; output register
   logic signed [SUM_W-1:0] px_ext, py_ext, dx_ext, dy_ext;
   logic [CB:0]             npx_clip, npy_clip;

   always_comb begin
      px_ext = {{(SUM_W - CB){p_px_ff[CB-1]}}, p_px_ff};
      py_ext = {{(SUM_W - CB){p_py_ff[CB-1]}}, p_py_ff};
      dx_ext = {{(SUM_W - CB){1'b0}}, p_dx_ff};
      dy_ext = {{(SUM_W - CB){1'b0}}, p_dy_ff};
      npx_clip = clip_coord(p_nvx_ff[CB-1] ? px_ext - dx_ext : px_ext + dx_ext);
      npy_clip = clip_coord(p_nvy_ff[CB-1] ? py_ext - dy_ext : py_ext + dy_ext);
   end

   logic             rsp_strobe_ff;
   cap_pkg::rsp_type rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= p_valid_ff;
      end
      rsp_item_ff.new_pos_x <= npx_clip[CB-1:0];
      rsp_item_ff.new_pos_y <= npy_clip[CB-1:0];
      rsp_item_ff.new_vel_x <= p_nvx_ff;
      rsp_item_ff.new_vel_y <= p_nvy_ff;
      rsp_item_ff.saturated <= p_clip_ff | npx_clip[CB] | npy_clip[CB];
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   // Zero radius exactly when the particle sits at the origin
   a_zero_radius: assert property (@(posedge clock) disable iff (reset)
      r_valid_ff |-> (r_zero_ff == (r_side_ff.mag_x == '0 && r_side_ff.mag_y == '0)))
      else $error("radius zero flag disagrees with position magnitudes");

   // Clamped pull stays within the configured bounds
   a_pull_bounds: assert property (@(posedge clock) disable iff (reset)
      (m_valid_ff && ($past(floor_ff) <= $past(ceil_ff)))
         |-> (m_ff >= $past(floor_ff) && m_ff <= $past(ceil_ff)))
      else $error("pull magnitude outside floor and ceiling");

endmodule

[verif/tb_central_attractor_particle_step.sv]
`timescale 1ns / 100ps

module tb_central_attractor_particle_step;

   localparam int PIPE_DEPTH  = 74;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   cap_pkg::req_type req_item = '0;
   logic rsp_strobe;
   cap_pkg::rsp_type rsp_item;
   logic csr_we = 1'b0;
   logic [cap_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [cap_pkg::CSR_BITS-1:0] csr_wdata = '0;

   central_attractor_particle_step uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predictor copy of the registers
   logic [63:0] step_dt, pull_num, acc_floor, acc_ceil;

   cap_pkg::req_type pending_particles[$];
   cap_pkg::rsp_type expected_particles[$];
   int  error_count = 0;
   int  cycle_count = 0;
   bit  hold_sender = 1'b0;
   int  burst_left = 0;
   int  gap_left = 0;

   function automatic logic [63:0] isqrt(logic [63:0] n);
      logic [63:0] root, b;
      root = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= root + b) begin
            n = n - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      return root;
   endfunction

   function automatic longint clip32(longint v, inout bit sat);
      if (v > 64'sd2147483647) begin
         sat = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         sat = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // Velocity change along one axis: pull toward origin
   function automatic longint pull_delta(logic [63:0] cmag, bit cneg,
                                         logic [63:0] r, logic [63:0] m);
      logic [63:0] u, acc, dv;
      if (r == 0) return 0;
      u = (cmag << 16) / r;
      if (u > 64'd65536) u = 64'd65536;
      acc = (m * u) >> 16;
      dv = (acc * step_dt) >> 16;
      return cneg ? longint'(dv) : -longint'(dv);
   endfunction

   function automatic longint drift_delta(longint v);
      logic [63:0] d;
      d = ((v < 0 ? -v : v) * step_dt) >> 16;
      return v < 0 ? -longint'(d) : longint'(d);
   endfunction

   function automatic cap_pkg::rsp_type advance_particle(cap_pkg::req_type p);
      longint px, py, vx, vy, nvx, nvy, npx, npy;
      logic [63:0] ax, ay, big, r, m;
      int sh;
      bit sat;
      cap_pkg::rsp_type res;
      px = p.pos_x; py = p.pos_y; vx = p.vel_x; vy = p.vel_y;
      ax = px < 0 ? -px : px;
      ay = py < 0 ? -py : py;
      big = ax > ay ? ax : ay;
      sh = 0;
      while ((big >> sh) >= 64'd2147483648) sh++;
      r = isqrt((ax >> sh) * (ax >> sh) + (ay >> sh) * (ay >> sh)) << sh;
      m = 0;
      if (r != 0) begin
         m = (pull_num << 16) / r;
         if (m < acc_floor) m = acc_floor;
         if (m > acc_ceil) m = acc_ceil;
      end
      sat = 1'b0;
      nvx = clip32(vx + pull_delta(ax, px < 0, r, m), sat);
      nvy = clip32(vy + pull_delta(ay, py < 0, r, m), sat);
      npx = clip32(px + drift_delta(nvx), sat);
      npy = clip32(py + drift_delta(nvy), sat);
      res.new_pos_x = npx[31:0];
      res.new_pos_y = npy[31:0];
      res.new_vel_x = nvx[31:0];
      res.new_vel_y = nvy[31:0];
      res.saturated = sat;
      return res;
   endfunction

   // Driver: bursts with random gaps
   always @(posedge clock) begin
      if (start && !busy) begin
         expected_particles.push_back(advance_particle(req_item));
         void'(pending_particles.pop_front());
      end
      if (!reset && !hold_sender && pending_particles.size() != 0 &&
          !(start && !busy && pending_particles.size() == 0)) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else begin
            start <= 1'b1;
            req_item <= pending_particles[0];
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end else begin
         start <= 1'b0;
      end
   end

   // Monitor
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
      if (rsp_strobe) begin
         if (expected_particles.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_item);
            error_count <= error_count + 1;
         end else begin
            if (rsp_item !== expected_particles[0]) begin
               $display("%0t: mismatch exp %h act %h", $time,
                        expected_particles[0], rsp_item);
               error_count <= error_count + 1;
            end
            void'(expected_particles.pop_front());
         end
      end
   end

   task automatic write_reg(cap_pkg::csr_index_type idx,
                            logic [cap_pkg::CSR_BITS-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         cap_pkg::CSR_TIME_STEP:     step_dt = 64'(val[cap_pkg::TS_BITS-1:0]);
         cap_pkg::CSR_PULL_STRENGTH: pull_num = 64'(val);
         cap_pkg::CSR_ACCEL_FLOOR:   acc_floor = 64'(val);
         default:                    acc_ceil = 64'(val);
      endcase
   endtask

   task automatic drain_all();
      while (pending_particles.size() != 0 || start || expected_particles.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
         2: return 32'($signed($urandom_range(0, 131072)) - 65536);
         default: return 32'($signed($urandom_range(0, 2 * (1 << 24))) - (1 << 24));
      endcase
   endfunction

   task automatic queue_particle(logic [31:0] a, b, c, d);
      cap_pkg::req_type p;
      p.pos_x = a; p.pos_y = b; p.vel_x = c; p.vel_y = d;
      pending_particles.push_back(p);
   endtask

   initial begin
      step_dt = 64'(cap_pkg::TIME_STEP_RESET);
      pull_num = 64'(cap_pkg::PULL_STRENGTH_RESET);
      acc_floor = 64'(cap_pkg::ACCEL_FLOOR_RESET);
      acc_ceil = 64'(cap_pkg::ACCEL_CEILING_RESET);
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: origin, extremes, axis points, overflow
      queue_particle(32'h0, 32'h0, 32'h0, 32'h0);
      queue_particle(32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000);
      queue_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      queue_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      queue_particle(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0);
      queue_particle(32'h1, 32'h0, 32'h0, 32'h0);
      queue_particle(32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0);
      queue_particle(32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000);
      queue_particle(32'h0064_0000, 32'hFF9C_0000, 32'h7FFF_0000, 32'h8001_0000);
      queue_particle(32'h0000_0100, 32'h0000_0100, 32'h0, 32'h0);
      drain_all();

      // Extreme configuration, including floor above ceiling
      write_reg(cap_pkg::CSR_TIME_STEP, 31'hFFFF);
      write_reg(cap_pkg::CSR_PULL_STRENGTH, 31'h7FFF_FFFF);
      write_reg(cap_pkg::CSR_ACCEL_FLOOR, 31'h7FFF_FFFF);
      write_reg(cap_pkg::CSR_ACCEL_CEILING, 31'h0001_0000);
      queue_particle(32'h0001_0000, 32'h0, 32'h7FFF_FFFF, 32'h0);
      queue_particle(32'hFFFF_0000, 32'h0002_0000, 32'h8000_0000, 32'h7FFF_FFFF);
      queue_particle(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0);
      queue_particle(32'h3, 32'h5, 32'h7, 32'h9);
      drain_all();
      write_reg(cap_pkg::CSR_TIME_STEP, 31'h0);
      write_reg(cap_pkg::CSR_PULL_STRENGTH, 31'h0);
      write_reg(cap_pkg::CSR_ACCEL_FLOOR, 31'h0);
      write_reg(cap_pkg::CSR_ACCEL_CEILING, 31'h7FFF_FFFF);
      queue_particle(32'h0001_0000, 32'h0001_0000, 32'h1234_5678, 32'h8765_4321);
      queue_particle(32'h0, 32'h0, 32'h5, 32'h5);
      drain_all();

      // Random phases over several settings
      for (int ph = 0; ph < 8; ph++) begin
         if (ph == 0) begin
            write_reg(cap_pkg::CSR_TIME_STEP, 31'(cap_pkg::TIME_STEP_RESET));
            write_reg(cap_pkg::CSR_PULL_STRENGTH, cap_pkg::PULL_STRENGTH_RESET);
            write_reg(cap_pkg::CSR_ACCEL_FLOOR, cap_pkg::ACCEL_FLOOR_RESET);
            write_reg(cap_pkg::CSR_ACCEL_CEILING, cap_pkg::ACCEL_CEILING_RESET);
         end else begin
            write_reg(cap_pkg::CSR_TIME_STEP, 31'($urandom_range(0, 65535)));
            write_reg(cap_pkg::CSR_PULL_STRENGTH,
                      ph[0] ? 31'($urandom) : 31'($urandom_range(0, 1 << 28)));
            write_reg(cap_pkg::CSR_ACCEL_FLOOR, 31'($urandom_range(0, 1 << 20)));
            write_reg(cap_pkg::CSR_ACCEL_CEILING,
                      ph == 7 ? 31'h7FFF_FFFF : 31'($urandom));
         end
         for (int i = 0; i < 200; i++)
            queue_particle(pick_coord(), pick_coord(), pick_coord(), pick_coord());
         // Hold the sender once mid-phase until the pipe is empty
         if (ph == 3) begin
            while (pending_particles.size() > 100) @(posedge clock);
            hold_sender = 1'b1;
            while (start || expected_particles.size() != 0) @(posedge clock);
            hold_sender = 1'b0;
         end
         drain_all();
      end

      repeat (PIPE_DEPTH + 10) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/cap_pkg.sv
hdl/cap_delay.sv
hdl/cap_sqrt.sv
hdl/cap_div.sv
hdl/central_attractor_particle_step.sv
verif/tb_central_attractor_particle_step.sv
